// ----- hw/rtl/tbn_pkg.sv -----
// Shared constants and types for the text byte normaliser.
`timescale 1ns / 1ps

package tbn_pkg;

    localparam logic [7:0] MARK_B0    = 8'hEF;
    localparam logic [7:0] MARK_B1    = 8'hBB;
    localparam logic [7:0] MARK_B2    = 8'hBF;
    localparam logic [7:0] CTRL_LIMIT = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_EF    = 2'd1,
        PH_EFBB  = 2'd2,
        PH_BODY  = 2'd3
    } tbn_phase_t;

    // One classified input item: up to three result bytes.
    typedef struct packed {
        logic [1:0]      cnt;
        logic            bare;
        logic            fin;
        logic [2:0][7:0] bytes;
    } tbn_job_t;

endpackage

// ----- hw/rtl/tbn_if.sv -----
// Valid/ready channel interfaces for input and result items.
`timescale 1ns / 1ps

interface tbn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface tbn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;

    modport source (output valid, output out_byte, output byte_valid, output end_of_text,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input end_of_text,
                    output ready);
endinterface

// ----- hw/rtl/tbn_front.sv -----
// Front end: accepts bytes, tracks mark and CR state, builds one job per item.
`timescale 1ns / 1ps

module tbn_front
    import tbn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    tbn_in_if.sink   text_in,
    input  logic     q_full,
    output logic     push,
    output tbn_job_t push_job
);

    tbn_phase_t phase_reg, phase_next;
    logic       cr_reg, cr_next;

    logic       fire;
    logic [7:0] b;
    logic       fin;

    logic       clean_v;
    logic [7:0] clean_b;
    logic       clean_cr;

    logic       use_clean;
    logic [1:0] pre_n;
    tbn_job_t   job;

    assign b             = text_in.data_byte;
    assign fin           = text_in.final_byte;
    assign text_in.ready = !q_full;
    assign fire          = text_in.valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            cr_reg    <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            cr_reg    <= cr_next;
        end
    end

    // Line-ending and control filter
    always_comb
    begin
        clean_v  = 1'b1;
        clean_b  = b;
        clean_cr = 1'b0;
        if (cr_reg && b == CH_LF)
        begin
            clean_v = 1'b0;
        end
        else if (b == CH_CR)
        begin
            clean_b  = CH_LF;
            clean_cr = 1'b1;
        end
        else if (b < CTRL_LIMIT && b != CH_TAB && b != CH_LF)
        begin
            clean_v = 1'b0;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        cr_next    = cr_reg;
        use_clean  = 1'b0;
        pre_n      = 2'd0;
        case (phase_reg)
            PH_START:
            begin
                if (b == MARK_B0)
                begin
                    phase_next = PH_EF;
                    pre_n      = fin ? 2'd1 : 2'd0;
                end
                else
                begin
                    phase_next = PH_BODY;
                    use_clean  = 1'b1;
                end
            end
            PH_EF:
            begin
                if (b == MARK_B1)
                begin
                    phase_next = PH_EFBB;
                    pre_n      = fin ? 2'd2 : 2'd0;
                end
                else
                begin
                    phase_next = PH_BODY;
                    pre_n      = 2'd1;
                    use_clean  = 1'b1;
                end
            end
            PH_EFBB:
            begin
                phase_next = PH_BODY;
                if (b != MARK_B2)
                begin
                    pre_n     = 2'd2;
                    use_clean = 1'b1;
                end
            end
            default:
            begin
                use_clean = 1'b1;
            end
        endcase

        if (use_clean)
            cr_next = clean_cr;

        job.cnt      = pre_n + {1'b0, use_clean && clean_v};
        job.bare     = 1'b0;
        job.fin      = fin;
        job.bytes[0] = (pre_n != 2'd0) ? MARK_B0 : clean_b;
        job.bytes[1] = (pre_n == 2'd2) ? MARK_B1 : clean_b;
        job.bytes[2] = clean_b;

        if (fin)
        begin
            if (job.cnt == 2'd0)
            begin
                job.cnt      = 2'd1;
                job.bare     = 1'b1;
                job.bytes[0] = 8'd0;
            end
            phase_next = PH_START;
            cr_next    = 1'b0;
        end
    end

    assign push     = fire && (job.cnt != 2'd0);
    assign push_job = job;

endmodule

// ----- hw/rtl/tbn_queue.sv -----
// Short job queue between the front and back ends.
`timescale 1ns / 1ps

module tbn_queue
    import tbn_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  tbn_job_t push_job,
    output logic     full,
    input  logic     pop,
    output tbn_job_t head_job,
    output logic     empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    tbn_job_t      mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == FULL_CNT);
    assign empty    = (cnt_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ----- hw/rtl/tbn_back.sv -----
// Back end: unpacks queued jobs into result items, one per cycle while text_out is ready.
`timescale 1ns / 1ps

module tbn_back
    import tbn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tbn_job_t head_job,
    input  logic     empty,
    output logic     pop,
    tbn_out_if.source text_out
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       byte_valid_reg;
    logic       eot_reg;

    logic       load;
    logic       last;
    logic [7:0] sel_byte;

    assign load = !empty && (!out_valid_reg || text_out.ready);
    assign last = (idx_reg == head_job.cnt - 2'd1);
    assign pop  = load && last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head_job.bytes[0];
            2'd1:    sel_byte = head_job.bytes[1];
            default: sel_byte = head_job.bytes[2];
        endcase
        idx_next = idx_reg;
        if (load)
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (text_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= sel_byte;
            byte_valid_reg <= !head_job.bare;
            eot_reg        <= head_job.fin && last;
        end
    end

    assign text_out.valid       = out_valid_reg;
    assign text_out.out_byte    = out_byte_reg;
    assign text_out.byte_valid  = byte_valid_reg;
    assign text_out.end_of_text = eot_reg;

endmodule

// ----- hw/rtl/text_byte_normalizer_core.sv -----
// Top level of the text byte normaliser.
`timescale 1ns / 1ps

// Cleans a text stream one byte per item: strips a leading UTF-8 byte-order
// mark, turns CR LF and lone CR into LF, and drops control bytes below 32
// other than tab, LF and CR. The item flagged final_byte always produces a
// result with end_of_text set (a bare marker with byte_valid clear if it
// yields no byte). Input is taken at one item per cycle while the job queue
// has room; results leave at one per cycle, while the output is ready, from a
// registered output, and each item yields 0 to 3 results. An item's job
// passes through the job queue and then the output register.

module text_byte_normalizer_core
    import tbn_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    tbn_in_if.sink    text_in,
    tbn_out_if.source text_out
);

    logic     q_full;
    logic     q_empty;
    logic     push;
    logic     pop;
    tbn_job_t push_job;
    tbn_job_t head_job;

    tbn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    tbn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    tbn_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .empty    (q_empty),
        .pop      (pop),
        .text_out (text_out)
    );

endmodule
